FILE: design/assert_macros.svh
// Assertion macros shared by the mean distance design.
// Each macro asserts at the rising edge of clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that holds at every clock edge.
`define MED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define MED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define MED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/med_pkg.sv
// Package of the mean Euclidean distance block: field widths, word types,
// register indexes and defaults. Depends on nothing.
package med_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned MEAN_W    = 25;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned SUM_W     = 35;
  localparam int unsigned SQSUM_W   = 33;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_POINTS_DEF = 1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REF_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_Y = 2'd1;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } in_word_t;

  typedef struct packed {
    logic [MEAN_W-1:0]  mean_distance;
    logic [COUNT_W-1:0] point_count;
    logic               overflow;
  } out_word_t;

endpackage

FILE: design/mean_euclidean_distance.sv
// Mean Euclidean distance of a point list to a configured reference point.
// A counted point is accepted only in idle, and the input stalls until its work,
// the 16-step shift-add squaring and the 25-step bit-serial square root, is done.
// A point past the maximum count is dropped and sets the overflow flag. A last
// point also runs the 35-step serial divide before its word appears.
// Reset clears the reference point, the sum, the count and the flag.
module mean_euclidean_distance #(
  parameter int unsigned MAX_POINTS = med_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [med_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [med_pkg::COORD_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  med_pkg::in_word_t                in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output med_pkg::out_word_t               out_word_o
);

  `include "assert_macros.svh"

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam int unsigned CW   = med_pkg::COORD_W;
  localparam int unsigned MulW = $clog2(CW + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_ABS    = 7'b0000010,
    ST_MUL    = 7'b0000100,
    ST_SUMSQ  = 7'b0001000,
    ST_ROOT   = 7'b0010000,
    ST_DSTART = 7'b0100000,
    ST_DIV    = 7'b1000000
  } state_e;

  state_e                         state_q, state_d;
  logic signed [CW-1:0]           ref_x_q, ref_y_q;
  logic signed [CW-1:0]           px_q, py_q;
  logic                           last_q;
  logic [CW-1:0]                  ax_q, ay_q;
  logic [2*CW-1:0]                mx_q, my_q;
  logic [MulW-1:0]                mul_cnt_q;
  logic [2*CW-1:0]                sqx_q, sqy_q;
  logic [med_pkg::SUM_W-1:0]      sum_q, sum_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic                           ovf_q, ovf_d;
  logic                           out_valid_q, out_valid_d;
  med_pkg::out_word_t             out_q;
  logic                           in_acc, out_acc, out_load;
  logic                           cnt_full;
  logic signed [CW:0]             dx, dy, nx, ny;
  logic [CW-1:0]                  abs_x, abs_y;
  logic                           sqrt_start, sqrt_busy;
  logic [med_pkg::MEAN_W-1:0]     root;
  logic [med_pkg::SQSUM_W-1:0]    sqsum;
  logic                           div_start, div_busy;
  logic [med_pkg::SUM_W-1:0]      quotient;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q <= '0;
      ref_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        med_pkg::REG_REF_X: ref_x_q <= cfg_data_i;
        med_pkg::REG_REF_Y: ref_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign cnt_full   = (cnt_q == CntW'(MAX_POINTS));

  // Differences are exact at 17 bits; their magnitudes fit in 16.
  always_comb begin
    dx    = {px_q[CW-1], px_q} - {ref_x_q[CW-1], ref_x_q};
    dy    = {py_q[CW-1], py_q} - {ref_y_q[CW-1], ref_y_q};
    nx    = '0 - dx;
    ny    = '0 - dy;
    abs_x = dx[CW] ? nx[CW-1:0] : dx[CW-1:0];
    abs_y = dy[CW] ? ny[CW-1:0] : dy[CW-1:0];
  end

  assign sqsum      = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign sqrt_start = (state_q == ST_SUMSQ);
  assign div_start  = (state_q == ST_DSTART);
  assign out_load   = (state_q == ST_DIV) && !div_busy && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cnt_full) begin
            ovf_d   = 1'b1;
            state_d = in_word_i.last_point ? ST_DSTART : ST_IDLE;
          end else begin
            state_d = ST_ABS;
          end
        end
      end
      ST_ABS:    state_d = ST_MUL;
      ST_MUL:    state_d = (mul_cnt_q == MulW'(1)) ? ST_SUMSQ : ST_MUL;
      ST_SUMSQ:  state_d = ST_ROOT;
      ST_ROOT: begin
        if (!sqrt_busy) begin
          sum_d   = sum_q + {{(med_pkg::SUM_W - med_pkg::MEAN_W){1'b0}}, root};
          cnt_d   = cnt_q + CntW'(1);
          state_d = last_q ? ST_DSTART : ST_IDLE;
        end
      end
      ST_DSTART: state_d = ST_DIV;
      ST_DIV: begin
        // The finished word waits here until the output register is free.
        if (out_load) begin
          out_valid_d = 1'b1;
          sum_d       = '0;
          cnt_d       = '0;
          ovf_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q   <= in_word_i.point_x;
      py_q   <= in_word_i.point_y;
      last_q <= in_word_i.last_point;
    end
    if (state_q == ST_ABS) begin
      ax_q      <= abs_x;
      ay_q      <= abs_y;
      mx_q      <= {{CW{1'b0}}, abs_x};
      my_q      <= {{CW{1'b0}}, abs_y};
      sqx_q     <= '0;
      sqy_q     <= '0;
      mul_cnt_q <= MulW'(CW);
    end
    if (state_q == ST_MUL) begin
      // Shift-add squaring: one multiplier bit per cycle, least significant first.
      if (ax_q[0]) sqx_q <= sqx_q + mx_q;
      if (ay_q[0]) sqy_q <= sqy_q + my_q;
      ax_q      <= ax_q >> 1;
      ay_q      <= ay_q >> 1;
      mx_q      <= mx_q << 1;
      my_q      <= my_q << 1;
      mul_cnt_q <= mul_cnt_q - MulW'(1);
    end
    if (out_load) begin
      out_q.mean_distance <= (cnt_q == '0) ? '0 : quotient[med_pkg::MEAN_W-1:0];
      out_q.point_count   <= med_pkg::COUNT_W'(cnt_q);
      out_q.overflow      <= ovf_q;
    end
  end

  med_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqsum),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  med_div #(
    .CntW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `MED_ASSERT(a_cnt_bound, cnt_q <= CntW'(MAX_POINTS), "Point count exceeds the maximum.")
  `MED_ASSERT_IMP(a_word_src, $rose(out_valid_q), $past(state_q) == ST_DIV, "Stray word.")
  `MED_ASSERT_IMP(a_clear_on_word, $rose(out_valid_q), cnt_q == '0 && !ovf_q, "List not cleared.")
  `MED_ASSERT_NXT(a_sqrt_runs, state_q == ST_SUMSQ, sqrt_busy, "Square root did not start.")

endmodule

FILE: design/med_isqrt.sv
// Bit-serial integer square root of a squared distance shifted left by 16.
// Two radicand bits enter per cycle; uses med_pkg for widths.
module med_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [med_pkg::SQSUM_W-1:0] rad_i,
  output logic                       busy_o,
  output logic [med_pkg::MEAN_W-1:0] root_o
);

  // The radicand is padded to an even width; sixteen zero bits follow it.
  localparam int unsigned RadW  = med_pkg::SQSUM_W + 1;
  localparam int unsigned Steps = med_pkg::MEAN_W;
  localparam int unsigned StepW = $clog2(Steps + 1);
  localparam int unsigned RemW  = med_pkg::MEAN_W + 1;

  logic [RadW-1:0]              rad_q, rad_d;
  logic [RemW-1:0]              rem_q, rem_d;
  logic [med_pkg::MEAN_W-1:0]   root_q, root_d;
  logic [StepW-1:0]             step_q, step_d;
  logic [RemW+1:0]              rem_sh;
  logic [RemW+1:0]              trial;

  always_comb begin
    rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    step_d = step_q;
    if (start_i) begin
      rad_d  = {1'b0, rad_i};
      rem_d  = '0;
      root_d = '0;
      step_d = StepW'(Steps);
    end else if (step_q != '0) begin
      rad_d  = {rad_q[RadW-3:0], 2'b00};
      step_d = step_q - StepW'(1);
      if (rem_sh >= trial) begin
        rem_d  = RemW'(rem_sh - trial);
        root_d = {root_q[med_pkg::MEAN_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[RemW-1:0];
        root_d = {root_q[med_pkg::MEAN_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = (step_q != '0);
  assign root_o = root_q;

endmodule

FILE: design/med_div.sv
// Bit-serial restoring divider for the distance sum over the point count.
// One quotient bit per cycle; uses med_pkg for the sum width.
module med_div #(
  parameter int unsigned CntW = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [med_pkg::SUM_W-1:0] dividend_i,
  input  logic [CntW-1:0]           divisor_i,
  output logic                      busy_o,
  output logic [med_pkg::SUM_W-1:0] quotient_o
);

  localparam int unsigned Steps = med_pkg::SUM_W;
  localparam int unsigned StepW = $clog2(Steps + 1);

  logic [med_pkg::SUM_W-1:0] quo_q, quo_d;
  logic [CntW-1:0]           rem_q, rem_d;
  logic [CntW-1:0]           dvs_q, dvs_d;
  logic [StepW-1:0]          step_q, step_d;
  logic [CntW:0]             rem_sh;
  logic                      fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[med_pkg::SUM_W-1]};
    fits   = (rem_sh >= {1'b0, dvs_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      step_d = StepW'(Steps);
    end else if (step_q != '0) begin
      // The dividend shifts out of the top while quotient bits enter below.
      quo_d  = {quo_q[med_pkg::SUM_W-2:0], fits};
      rem_d  = fits ? CntW'(rem_sh - {1'b0, dvs_q}) : rem_sh[CntW-1:0];
      step_d = step_q - StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = (step_q != '0);
  assign quotient_o = quo_q;

endmodule
